// ===== rtl/tfi_pkg.sv =====
// Shared widths, constants and codes for the thin-film interference pipeline.
package tfi_pkg;

  localparam int unsigned ThickW   = 11;
  localparam int unsigned IndexW   = 14;
  localparam int unsigned CosW     = 16;
  localparam int unsigned IntW     = 16;
  localparam int unsigned CfgDataW = 14;
  localparam int unsigned RadW     = 34;
  localparam int unsigned RootW    = 17;
  localparam int unsigned PathW    = 30;

  localparam int unsigned FrontLat  = 2;
  localparam int unsigned SqrtLat   = RootW;
  localparam int unsigned PathLat   = 1;
  localparam int unsigned FringeLat = 9;
  localparam int unsigned TotalLat  = FrontLat + SqrtLat + PathLat + FringeLat;

  localparam logic [ThickW-1:0] ThickReset = 11'd500;
  localparam logic [IndexW-1:0] IndexReset = 14'd5448;

  localparam logic [31:0] OneQ30 = 32'd1073741824;
  localparam logic [30:0] CosC2  = 31'd1324675879;
  localparam logic [28:0] CosC4  = 29'd272375560;
  localparam logic [24:0] CosC6  = 25'd22401992;
  localparam logic [19:0] CosC8  = 20'd987048;

  localparam int unsigned LambdaRed   = 650;
  localparam int unsigned LambdaGreen = 510;
  localparam int unsigned LambdaBlue  = 475;

  typedef enum logic [0:0] {
    CfgThickness = 1'b0,
    CfgIndex     = 1'b1
  } cfg_idx_e;

endpackage

// ===== rtl/thin_film_interference_rgb.sv =====
// Top level of the thin-film interference block for red, green and blue.
// One beat enters per cycle and passes through every stage in order: the squaring
// registers and then the radicand register form n^2 - sin^2, seventeen stages of
// the square-root pipeline produce one root bit each, the path register forms the
// path, and nine per-color stages divide by the wavelength and evaluate the cosine
// polynomial. The whole pipeline holds while a finished beat waits at a stalled
// output, so the sustained rate is one beat per cycle whenever the output side takes beats.
module thin_film_interference_rgb (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [tfi_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [tfi_pkg::CosW-1:0] view_cosine_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tfi_pkg::IntW-1:0]      intensity_red_o,
  output logic [tfi_pkg::IntW-1:0]      intensity_green_o,
  output logic [tfi_pkg::IntW-1:0]      intensity_blue_o
);
  import tfi_pkg::*;

  logic [ThickW-1:0]  thick_q;
  logic [IndexW-1:0]  index_q;
  logic [TotalLat-1:0] valid_q;
  logic               en;

  logic [16:0]        mag;
  logic [30:0]        sq_q;
  logic [RadW-1:0]    nsq_q;
  logic [30:0]        s;
  logic [RadW-1:0]    rad_q;
  logic [RootW-1:0]   root;
  logic [27:0]        dm_q;
  logic [PathW-1:0]   x;

  assign en          = !(valid_q[TotalLat-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = valid_q[TotalLat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thick_q <= ThickReset;
      index_q <= IndexReset;
      valid_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CfgThickness: thick_q <= cfg_data_i[ThickW-1:0];
          CfgIndex:     index_q <= cfg_data_i[IndexW-1:0];
          default:      ;
        endcase
      end
      if (en) begin
        valid_q <= {valid_q[TotalLat-2:0], in_valid_i};
      end
    end
  end

  always_comb begin
    mag = view_cosine_i[CosW-1] ? 17'(17'd65536 - 17'({1'b0, view_cosine_i}))
                                : 17'({1'b0, view_cosine_i});
    s   = 31'(OneQ30) - sq_q;
    x   = PathW'({dm_q, 2'b00});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q  <= 31'(mag * mag);
      nsq_q <= RadW'({28'(index_q * index_q), 6'b000000});
      rad_q <= (nsq_q > RadW'(s)) ? RadW'(nsq_q - RadW'(s)) : '0;
      dm_q  <= 28'(thick_q * root);
    end
  end

  tfi_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (root)
  );

  tfi_fringe #(.Lambda(LambdaRed)) u_red (
    .clk_i       (clk_i),
    .en_i        (en),
    .x_i         (x),
    .intensity_o (intensity_red_o)
  );

  tfi_fringe #(.Lambda(LambdaGreen)) u_green (
    .clk_i       (clk_i),
    .en_i        (en),
    .x_i         (x),
    .intensity_o (intensity_green_o)
  );

  tfi_fringe #(.Lambda(LambdaBlue)) u_blue (
    .clk_i       (clk_i),
    .en_i        (en),
    .x_i         (x),
    .intensity_o (intensity_blue_o)
  );

endmodule

// ===== rtl/tfi_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
module tfi_sqrt (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [tfi_pkg::RadW-1:0]  rad_i,
  output logic [tfi_pkg::RootW-1:0] root_o
);
  import tfi_pkg::*;

  localparam int unsigned W = RadW + 1;

  logic [W-1:0] v_q   [1:SqrtLat];
  logic [W-1:0] res_q [1:SqrtLat];

  for (genvar k = 0; k < SqrtLat; k++) begin : g_stage
    localparam logic [W-1:0] Bit = W'(1) << (2 * (SqrtLat - 1 - k));
    logic [W-1:0] v_in;
    logic [W-1:0] res_in;
    logic [W-1:0] trial;
    if (k == 0) begin : g_first
      assign v_in   = W'(rad_i);
      assign res_in = '0;
    end else begin : g_next
      assign v_in   = v_q[k];
      assign res_in = res_q[k];
    end
    assign trial = res_in + Bit;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_in >= trial) begin
          v_q[k+1]   <= v_in - trial;
          res_q[k+1] <= (res_in >> 1) + Bit;
        end else begin
          v_q[k+1]   <= v_in;
          res_q[k+1] <= res_in >> 1;
        end
      end
    end
  end

  assign root_o = res_q[SqrtLat][RootW-1:0];

endmodule

// ===== rtl/tfi_fringe.sv =====
// Fringe phase and cos-squared intensity for one wavelength, nine register stages.
module tfi_fringe #(
  parameter int unsigned Lambda = tfi_pkg::LambdaRed
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [tfi_pkg::PathW-1:0] x_i,
  output logic [tfi_pkg::IntW-1:0]  intensity_o
);
  import tfi_pkg::*;

  localparam int unsigned RecW = 22;
  localparam logic [RecW-1:0] Recip = RecW'((1 << 30) / Lambda);
  localparam logic [9:0] LambdaW = 10'(Lambda);

  logic [PathW+RecW-1:0] prod_q;
  logic [PathW-1:0]      x1_q;
  logic [RecW-1:0]       qe_q;
  logic [30:0]           rem_q;
  logic [14:0]           b_q;
  logic [30:0]           z2_q [4:7];
  logic [24:0]           t6_q;
  logic [28:0]           t4_q;
  logic [30:0]           t2_q;
  logic [31:0]           t_q;
  logic                  neg_q [3:8];

  logic [RecW-1:0] qe;
  logic [31:0]     qe_lam;
  logic [15:0]     w;
  logic [16:0]     a;
  logic            neg;
  logic [29:0]     bb;
  logic [50:0]     p5;
  logic [55:0]     p6;
  logic [59:0]     p7;
  logic [61:0]     p8;
  logic [30:0]     f;
  logic [31:0]     v;
  logic [16:0]     q;

  always_comb begin
    qe     = prod_q[PathW+RecW-1:30];
    qe_lam = 32'(qe * LambdaW);
    w      = 16'(qe_q + RecW'(rem_q >= 31'(LambdaW)));
    a      = w[15] ? 17'(17'd65536 - 17'(w)) : 17'(w);
    neg    = a > 17'd16384;
    bb     = 30'(b_q * b_q);
    p5     = 51'(z2_q[4] * CosC8);
    p6     = 56'(z2_q[5] * t6_q);
    p7     = 60'(z2_q[6] * t4_q);
    p8     = 62'(z2_q[7] * t2_q);
    f      = (t_q >= OneQ30) ? 31'd0 : 31'(OneQ30 - t_q);
    v      = neg_q[8] ? 32'(OneQ30 - 32'(f)) : 32'(OneQ30 + 32'(f));
    q      = 17'(((v >> 1) + 32'd8192) >> 14);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= (PathW+RecW)'(x_i * Recip);
      x1_q     <= x_i;
      qe_q     <= qe;
      rem_q    <= 31'({1'b0, x1_q}) - 31'(qe_lam);
      b_q      <= neg ? 15'(17'd32768 - a) : 15'(a);
      neg_q[3] <= neg;
      z2_q[4]  <= 31'({bb, 2'b00});
      z2_q[5]  <= z2_q[4];
      z2_q[6]  <= z2_q[5];
      z2_q[7]  <= z2_q[6];
      for (int i = 4; i <= 8; i++) neg_q[i] <= neg_q[i-1];
      t6_q <= 25'(CosC6 - 25'(p5 >> 30));
      t4_q <= 29'(CosC4 - 29'(p6 >> 30));
      t2_q <= 31'(CosC2 - 31'(p7 >> 30));
      t_q  <= 32'(p8 >> 30);
      intensity_o <= (q > 17'd65535) ? 16'hFFFF : q[15:0];
    end
  end

endmodule

// ===== rtl/tfi_checker.sv =====
// Port-level checks for the thin-film interference block and their binding.
module tfi_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [tfi_pkg::IntW-1:0]     intensity_red_o,
  input logic [tfi_pkg::IntW-1:0]     intensity_green_o,
  input logic [tfi_pkg::IntW-1:0]     intensity_blue_o
);

  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output backpressure");

  a_held_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(intensity_red_o)
      && $stable(intensity_green_o) && $stable(intensity_blue_o))
    else $error("stalled output beat changed");

  a_empty_after_reset: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("output beat right after reset");

endmodule

bind thin_film_interference_rgb tfi_checker u_tfi_checker (.*);
